@@ design/pixel_format_converter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Shorthand for the concurrent checks used in the converter RTL.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_TOP_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel format converter check failed");

// Next-cycle implication, disabled while reset is asserted
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel format converter check failed");

`endif

@@ design/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter package
// Widths, format codes and transaction payload types shared by the channels and RTL.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned PixelWidth  = 32;
  localparam int unsigned FormatWidth = 3;
  localparam logic [FormatWidth-1:0] DestFormatReset = 3'd2;

  // Codes 0 and 7 are invalid and handled by default arms
  typedef enum logic [FormatWidth-1:0] {
    FMT_RGBX8888 = 3'd1,
    FMT_XRGB8888 = 3'd2,
    FMT_RGB888   = 3'd3,
    FMT_XRGB1555 = 3'd4,
    FMT_RGB565   = 3'd5,
    FMT_GREY8    = 3'd6
  } fmt_e;

  typedef struct packed {
    logic [PixelWidth-1:0]  source_pixel;
    logic [FormatWidth-1:0] source_format;
    logic                   last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PixelWidth-1:0] dest_pixel;
    logic                  bad_format;
    logic                  last_out;
  } out_item_t;

endpackage

@@ design/pfc_if.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter channels
// Valid/ready stream interfaces for source pixels and converted pixels.
// ----------------------------------------------------------------------------
interface pfc_in_if;
  import pfc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PixelWidth-1:0]  source_pixel;
  logic [FormatWidth-1:0] source_format;
  logic                   last_pixel;

  modport source (output valid, output source_pixel, output source_format,
                  output last_pixel, input ready);
  modport sink   (input valid, input source_pixel, input source_format,
                  input last_pixel, output ready);
endinterface

interface pfc_out_if;
  import pfc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PixelWidth-1:0] dest_pixel;
  logic                  bad_format;
  logic                  last_out;

  modport source (output valid, output dest_pixel, output bad_format,
                  output last_out, input ready);
  modport sink   (input valid, input dest_pixel, input bad_format,
                  input last_out, output ready);
endinterface

@@ design/pixel_format_converter_top.sv @@
// An input transaction passes through the input register, then the result
// register. Throughput: one pixel per cycle while the result side is ready.
// The conversion (unpack, grey sum and divide-by-3, pack) sits between the
// two registers. Reset clears both stage valid bits and sets the destination
// format register to XRGB8888.
// ----------------------------------------------------------------------------
// Pixel format converter
// Converts one pixel per transaction between six RGB/grey formats.
// ----------------------------------------------------------------------------
module pixel_format_converter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            dest_format_we_i,
  input  logic [pfc_pkg::FormatWidth-1:0] dest_format_i,
  pfc_in_if.sink                          src_i,
  pfc_out_if.source                       dst_o
);
  import pfc_pkg::*;

  `include "pixel_format_converter_top_assert.svh"

  logic [FormatWidth-1:0] dest_format_q;

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      s2_valid_q, s2_valid_d;
  out_item_t s2_item_q, s2_item_d;

  logic src_accept;
  logic s2_load;

  // Stage 2 loads whenever it is empty or its transaction leaves this cycle
  assign s2_load    = ~s2_valid_q | dst_o.ready;
  assign src_i.ready = ~s1_valid_q | s2_load;
  assign src_accept = src_i.valid & src_i.ready;

  assign s1_valid_d = src_accept | (s1_valid_q & ~s2_load);
  assign s2_valid_d = s2_load ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_format_q <= DestFormatReset;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
    end else begin
      if (dest_format_we_i) begin
        dest_format_q <= dest_format_i;
      end
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_accept) begin
      s1_item_q.source_pixel  <= src_i.source_pixel;
      s1_item_q.source_format <= src_i.source_format;
      s1_item_q.last_pixel    <= src_i.last_pixel;
    end
    if (s2_load && s1_valid_q) begin
      s2_item_q <= s2_item_d;
    end
  end

  // Conversion
  logic [PixelWidth-1:0] pix;
  logic [7:0]            r, g, b;
  logic [9:0]            rgb_sum;
  logic [19:0]           grey_prod;
  logic [7:0]            grey;
  logic [PixelWidth-1:0] width_mask;
  logic [PixelWidth-1:0] packed_pix;
  logic                  src_bad;

  assign pix = s1_item_q.source_pixel;

  always_comb begin
    case (fmt_e'(s1_item_q.source_format))
      FMT_RGBX8888: begin
        r = pix[31:24]; g = pix[23:16]; b = pix[15:8];
      end
      FMT_XRGB8888, FMT_RGB888: begin
        r = pix[23:16]; g = pix[15:8]; b = pix[7:0];
      end
      FMT_XRGB1555: begin
        r = {pix[14:10], 3'b000}; g = {pix[9:5], 3'b000}; b = {pix[4:0], 3'b000};
      end
      FMT_RGB565: begin
        r = {pix[15:11], 3'b000}; g = {pix[10:5], 2'b00}; b = {pix[4:0], 3'b000};
      end
      default: begin
        r = pix[7:0]; g = pix[7:0]; b = pix[7:0];
      end
    endcase
  end

  // floor(x/3) as (x * 683) >> 11, exact for x up to 765
  assign rgb_sum   = {2'b00, r} + {2'b00, g} + {2'b00, b};
  assign grey_prod = rgb_sum * 10'd683;
  assign grey      = grey_prod[18:11];

  always_comb begin
    case (fmt_e'(dest_format_q))
      FMT_RGBX8888: packed_pix = {r, g, b, 8'hff};
      FMT_XRGB8888: packed_pix = {8'hff, r, g, b};
      FMT_RGB888:   packed_pix = {8'h00, r, g, b};
      FMT_XRGB1555: packed_pix = {16'h0000, 1'b1, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565:   packed_pix = {16'h0000, r[7:3], g[7:2], b[7:3]};
      FMT_GREY8:    packed_pix = {24'h000000, grey};
      default:      packed_pix = '0;
    endcase
  end

  always_comb begin
    case (fmt_e'(s1_item_q.source_format))
      FMT_RGBX8888, FMT_XRGB8888: width_mask = 32'hffff_ffff;
      FMT_RGB888:                 width_mask = 32'h00ff_ffff;
      FMT_XRGB1555, FMT_RGB565:   width_mask = 32'h0000_ffff;
      FMT_GREY8:                  width_mask = 32'h0000_00ff;
      default:                    width_mask = '0;
    endcase
  end

  assign src_bad = (s1_item_q.source_format == 3'd0) | (&s1_item_q.source_format);

  always_comb begin
    s2_item_d.bad_format = src_bad;
    s2_item_d.last_out   = s1_item_q.last_pixel;
    if (src_bad) begin
      s2_item_d.dest_pixel = '0;
    end else if (s1_item_q.source_format == dest_format_q) begin
      s2_item_d.dest_pixel = pix & width_mask;
    end else begin
      s2_item_d.dest_pixel = packed_pix;
    end
  end

  assign dst_o.valid      = s2_valid_q;
  assign dst_o.dest_pixel = s2_item_q.dest_pixel;
  assign dst_o.bad_format = s2_item_q.bad_format;
  assign dst_o.last_out   = s2_item_q.last_out;

  // Checks
  `PFC_ASSERT_IMPL(a_bad_zero, clk_i, rst_ni, s2_valid_q && s2_item_q.bad_format,
                   s2_item_q.dest_pixel == '0)
  `PFC_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, src_accept, s1_valid_q)
  `PFC_ASSERT_NEXT(a_s1_moves_on, clk_i, rst_ni, s1_valid_q && s2_load, s2_valid_q)
  `PFC_ASSERT_IMPL(a_s2_from_s1, clk_i, rst_ni, $rose(s2_valid_q), $past(s1_valid_q))

endmodule

@@ dv/pixel_format_converter_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel format converter testbench
// Drives source pixels through the valid/ready channels under random idling
// and back-pressure, and compares every converted pixel against a predictor.
// The destination format is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module pixel_format_converter_top_test;
  import pfc_pkg::*;

  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhasePixels  = 140;
  localparam int unsigned DrainCycles  = 4;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each converted pixel and checks results in order
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    out_item_t              converted_pixels[$];
    logic [FormatWidth-1:0] dest_fmt = DestFormatReset;
    int                     errors   = 0;

    function automatic out_item_t convert_pixel(in_item_t px);
      out_item_t              res;
      logic [PixelWidth-1:0]  p;
      logic [7:0]             r, g, b;
      logic [9:0]             sum;
      logic [9:0]             quot;
      p              = px.source_pixel;
      res.dest_pixel = '0;
      res.bad_format = 1'b0;
      res.last_out   = px.last_pixel;
      r = '0;
      g = '0;
      b = '0;
      if (px.source_format == 3'd0 || px.source_format == 3'd7) begin
        res.bad_format = 1'b1;
      end else if (px.source_format == dest_fmt) begin
        case (dest_fmt)
          FMT_RGBX8888, FMT_XRGB8888: res.dest_pixel = p;
          FMT_RGB888:                 res.dest_pixel = {8'h00, p[23:0]};
          FMT_XRGB1555, FMT_RGB565:   res.dest_pixel = {16'h0000, p[15:0]};
          default:                    res.dest_pixel = {24'h000000, p[7:0]};
        endcase
      end else begin
        case (px.source_format)
          FMT_RGBX8888: begin
            r = p[31:24]; g = p[23:16]; b = p[15:8];
          end
          FMT_XRGB8888, FMT_RGB888: begin
            r = p[23:16]; g = p[15:8]; b = p[7:0];
          end
          FMT_XRGB1555: begin
            r = {p[14:10], 3'b000}; g = {p[9:5], 3'b000}; b = {p[4:0], 3'b000};
          end
          FMT_RGB565: begin
            r = {p[15:11], 3'b000}; g = {p[10:5], 2'b00}; b = {p[4:0], 3'b000};
          end
          default: begin
            r = p[7:0]; g = p[7:0]; b = p[7:0];
          end
        endcase
        sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
        quot = sum / 10'd3;
        case (dest_fmt)
          FMT_RGBX8888: res.dest_pixel = {r, g, b, 8'hff};
          FMT_XRGB8888: res.dest_pixel = {8'hff, r, g, b};
          FMT_RGB888:   res.dest_pixel = {8'h00, r, g, b};
          FMT_XRGB1555: res.dest_pixel = {16'h0000, 1'b1, r[7:3], g[7:3], b[7:3]};
          FMT_RGB565:   res.dest_pixel = {16'h0000, r[7:3], g[7:2], b[7:3]};
          FMT_GREY8:    res.dest_pixel = {24'h000000, quot[7:0]};
          default:      res.dest_pixel = '0;
        endcase
      end
      return res;
    endfunction

    task report_mismatch(string field, logic [PixelWidth-1:0] got,
                         logic [PixelWidth-1:0] want);
      $display("%0t: mismatch on %s: got %h, wanted %h", $realtime, field, got, want);
      errors++;
    endtask

    function void note_pixel(in_item_t px);
      converted_pixels.push_back(convert_pixel(px));
    endfunction

    task check_pixel(out_item_t got);
      out_item_t want;
      if (converted_pixels.size() == 0) begin
        report_mismatch("unexpected transaction", got.dest_pixel, '0);
      end else begin
        want = converted_pixels.pop_front();
        if (got.dest_pixel !== want.dest_pixel)
          report_mismatch("dest_pixel", got.dest_pixel, want.dest_pixel);
        if (got.bad_format !== want.bad_format)
          report_mismatch("bad_format", PixelWidth'(got.bad_format),
                          PixelWidth'(want.bad_format));
        if (got.last_out !== want.last_out)
          report_mismatch("last_out", PixelWidth'(got.last_out),
                          PixelWidth'(want.last_out));
      end
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [FormatWidth-1:0] cfg_data;

  pfc_in_if  src_if ();
  pfc_out_if dst_if ();

  pixel_format_converter_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dest_format_we_i (cfg_we),
    .dest_format_i    (cfg_data),
    .src_i            (src_if),
    .dst_o            (dst_if)
  );

  pixel_scoreboard sb = new;

  int unsigned src_gap_max = 0;
  int unsigned dst_gap_max = 0;
  bit          long_hold   = 1'b0;
  int unsigned stall_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: watchdog expired", $realtime);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random ready gaps, one long hold-off on request
  initial begin
    int unsigned gap;
    out_item_t   got;
    dst_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        gap       = LongHold;
      end else begin
        gap = $urandom_range(0, dst_gap_max);
      end
      if (gap > 0) begin
        dst_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      dst_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!dst_if.valid) @(posedge clk_i);
      got.dest_pixel = dst_if.dest_pixel;
      got.bad_format = dst_if.bad_format;
      got.last_out   = dst_if.last_out;
      sb.check_pixel(got);
    end
  end

  task automatic send_pixel(in_item_t px);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_if.valid         <= 1'b1;
    src_if.source_pixel  <= px.source_pixel;
    src_if.source_format <= px.source_format;
    src_if.last_pixel    <= px.last_pixel;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
    sb.note_pixel(px);
  endtask

  // Lower valid, let every result come back, then let the pipe settle
  task automatic drain_pipe();
    src_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.converted_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_dest_format(logic [FormatWidth-1:0] fmt);
    cfg_we   <= 1'b1;
    cfg_data <= fmt;
    @(posedge clk_i);
    sb.dest_fmt = fmt;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t make_pixel(logic [PixelWidth-1:0] pix,
                                          logic [FormatWidth-1:0] fmt, logic last);
    in_item_t px;
    px.source_pixel  = pix;
    px.source_format = fmt;
    px.last_pixel    = last;
    return px;
  endfunction

  function automatic in_item_t random_pixel(logic [FormatWidth-1:0] dest);
    in_item_t    px;
    int unsigned pick;
    px.source_pixel = $urandom();
    pick = $urandom_range(0, 19);
    if (pick == 0)
      px.source_pixel = '0;
    else if (pick == 1)
      px.source_pixel = '1;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      px.source_format = 3'd0;
    else if (pick == 1)
      px.source_format = 3'd7;
    else if (pick < 5)
      px.source_format = dest;  // pass-through
    else
      px.source_format = FormatWidth'($urandom_range(1, 6));
    px.last_pixel = ($urandom_range(0, 7) == 0);
    return px;
  endfunction

  initial begin
    logic [FormatWidth-1:0] dest;
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_data             <= '0;
    src_if.valid         <= 1'b0;
    src_if.source_pixel  <= '0;
    src_if.source_format <= '0;
    src_if.last_pixel    <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset destination (XRGB8888): every source code, all-ones and all-zeros
    for (int f = 0; f < 8; f++) begin
      send_pixel(make_pixel('1, f[FormatWidth-1:0], 1'b1));
      send_pixel(make_pixel('0, f[FormatWidth-1:0], 1'b0));
    end
    drain_pipe();

    // Grey destination: truncating divide and the narrow-channel sources
    write_dest_format(FMT_GREY8);
    send_pixel(make_pixel(32'h00fffefd, FMT_XRGB8888, 1'b0));
    send_pixel(make_pixel(32'h01020300, FMT_RGBX8888, 1'b1));
    send_pixel(make_pixel(32'h0000ffff, FMT_XRGB1555, 1'b0));
    send_pixel(make_pixel(32'hffffffff, FMT_RGB565, 1'b1));
    send_pixel(make_pixel(32'hffffff80, FMT_GREY8, 1'b0));
    drain_pipe();

    for (int ph = 0; ph < NumPhases; ph++) begin
      dest = (ph < 6) ? FormatWidth'(int'(FMT_RGBX8888) + ph)
                      : FormatWidth'($urandom_range(1, 6));
      write_dest_format(dest);
      src_gap_max = (ph % 3 == 0) ? 0 : 13;
      dst_gap_max = (ph % 4 == 1) ? 0 : 13;
      if (ph == 2) begin
        // sender keeps offering while the result side holds off
        src_gap_max = 0;
        long_hold   = 1'b1;
      end
      for (int n = 0; n < PhasePixels; n++)
        send_pixel(random_pixel(dest));
      drain_pipe();
    end

    repeat (10) @(posedge clk_i);
    if (sb.converted_pixels.size() != 0)
      sb.report_mismatch("missing transactions", sb.converted_pixels.size(), 0);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/pfc_pkg.sv
design/pfc_if.sv
design/pixel_format_converter_top.sv
dv/pixel_format_converter_top_test.sv
